// ===== design/hpos_pkg.sv =====
package hpos_pkg;

    localparam int MAX_WIDTH_DEF = 2048;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 2'd2;

    localparam logic [11:0] WIDTH_RST    = 12'd640;
    localparam logic [11:0] HEIGHT_RST   = 12'd480;
    localparam logic [7:0]  STRENGTH_RST = 8'd10;

    typedef struct packed {
        logic accept;
        logic rd;
        logic c1;
        logic c2;
        logic c3;
        logic c4;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic ignore;
        logic emit;
        logic out_free;
    } t_sts;

endpackage

// ===== design/hpos_ctrl.sv =====
module hpos_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  hpos_pkg::t_sts i_sts,
    output hpos_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_C1   = 3'd2;
    localparam logic [2:0] S_C2   = 3'd3;
    localparam logic [2:0] S_C3   = 3'd4;
    localparam logic [2:0] S_C4   = 3'd5;
    localparam logic [2:0] S_C5   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid && !i_sts.ignore) n_state = S_RD;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state = i_sts.emit ? S_C1 : S_IDLE;
            end
            S_C1: begin
                o_cmd.c1 = 1'b1;
                n_state = S_C2;
            end
            S_C2: begin
                o_cmd.c2 = 1'b1;
                n_state = S_C3;
            end
            S_C3: begin
                o_cmd.c3 = 1'b1;
                n_state = S_C4;
            end
            S_C4: begin
                o_cmd.c4 = 1'b1;
                n_state = S_C5;
            end
            S_C5: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

endmodule

// ===== design/hpos_datapath.sv =====
module hpos_datapath #(
    parameter int MAX_WIDTH = hpos_pkg::MAX_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hpos_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hpos_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  hpos_pkg::t_cmd                  i_cmd,
    output hpos_pkg::t_sts                  o_sts,
    input  logic [7:0]                      i_pix_red,
    input  logic [7:0]                      i_pix_green,
    input  logic [7:0]                      i_pix_blue,
    input  logic                            i_flush,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_out_red,
    output logic [7:0]                      o_out_green,
    output logic [7:0]                      o_out_blue,
    output logic                            o_frame_last
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam logic [15:0] MAXW = 16'(MAX_WIDTH);

    logic [11:0] r_width;
    logic [11:0] r_height;
    logic [7:0]  r_strength;

    logic [23:0] row_a [MAX_WIDTH];
    logic [23:0] row_b [MAX_WIDTH];
    logic [23:0] r_win [9];

    logic [15:0] r_in_col;
    logic [11:0] r_in_row;
    logic [11:0] r_out_col;
    logic [11:0] r_out_row;

    logic [23:0] r_pix;
    logic        r_drain;
    logic        r_in_rng;
    logic [23:0] r_top;
    logic [23:0] r_mid;
    logic        r_lft;
    logic        r_rgt;
    logic        r_up;
    logic        r_dn;
    logic        r_last;

    logic [2:0][13:0] r_sum;
    logic [2:0][19:0] r_prod;
    logic [2:0][7:0]  r_hp;
    logic [2:0][16:0] r_x;

    logic        r_out_valid;
    logic [23:0] r_out;
    logic        r_out_last;

    logic [15:0] wv;
    logic [15:0] hv;
    logic        drain;
    logic        emit;
    logic [15:0] oc1;
    logic [15:0] or1;
    logic        last;
    logic [15:0] ic1;

    assign wv = ({4'd0, r_width} < 16'd2) ? 16'd2 :
                (({4'd0, r_width} > MAXW) ? MAXW : {4'd0, r_width});
    assign hv = ({4'd0, r_height} < 16'd2) ? 16'd2 : {4'd0, r_height};
    assign drain = {4'd0, r_in_row} >= hv;
    assign emit = (r_in_row >= 12'd2) || (r_in_row == 12'd1 && r_in_col >= 16'd1);
    assign oc1 = {4'd0, r_out_col} + 16'd1;
    assign or1 = {4'd0, r_out_row} + 16'd1;
    assign last = (or1 >= hv) && (oc1 >= wv);
    assign ic1 = r_in_col + 16'd1;

    assign o_sts.ignore = i_flush && !drain;
    assign o_sts.emit = emit;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= hpos_pkg::WIDTH_RST;
            r_height <= hpos_pkg::HEIGHT_RST;
            r_strength <= hpos_pkg::STRENGTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                hpos_pkg::REG_WIDTH:    r_width <= i_cfg_data;
                hpos_pkg::REG_HEIGHT:   r_height <= i_cfg_data;
                hpos_pkg::REG_STRENGTH: r_strength <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pix <= {i_pix_blue, i_pix_green, i_pix_red};
            r_drain <= drain;
            r_in_rng <= r_in_col < MAXW;
            r_top <= row_b[r_in_col[AW-1:0]];
            r_mid <= row_a[r_in_col[AW-1:0]];
        end
        if (i_cmd.rd && !r_drain && r_in_rng) begin
            row_b[r_in_col[AW-1:0]] <= r_mid;
            row_a[r_in_col[AW-1:0]] <= r_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            for (int k = 0; k < 6; k++) r_win[k] <= r_win[k+3];
            r_win[6] <= r_top;
            r_win[7] <= r_mid;
            r_win[8] <= r_drain ? 24'd0 : r_pix;
            r_lft <= r_out_col != 12'd0;
            r_rgt <= oc1 < wv;
            r_up <= r_out_row != 12'd0;
            r_dn <= or1 < hv;
            r_last <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col <= '0;
            r_in_row <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (i_cmd.rd) begin
            if (emit && last) begin
                r_in_col <= '0;
                r_in_row <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                if (r_drain) begin
                    if (r_in_col != 16'hFFFF) r_in_col <= ic1;
                end else if (ic1 >= wv) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + 12'd1;
                end else begin
                    r_in_col <= ic1;
                end
                if (emit) begin
                    if (oc1 >= wv) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + 12'd1;
                    end else begin
                        r_out_col <= r_out_col + 12'd1;
                    end
                end
            end
        end
    end

    logic [2:0][13:0] n_sum;
    logic [2:0][19:0] n_prod;
    logic [2:0][7:0]  n_hp;
    logic [2:0][16:0] n_x;
    logic [2:0][7:0]  n_res;

    always_comb begin
        logic [13:0] c, e, d;
        logic [23:0] q10;
        logic [7:0]  lv, m;
        logic [25:0] q0w;
        logic [16:0] q0;
        logic [17:0] rem;
        logic [16:0] q;
        logic [16:0] rr;
        for (int ch = 0; ch < 3; ch++) begin
            c = {6'd0, r_win[4][ch*8 +: 8]};
            e = '0;
            d = '0;
            if (r_up) e = e + {6'd0, r_win[3][ch*8 +: 8]};
            if (r_dn) e = e + {6'd0, r_win[5][ch*8 +: 8]};
            if (r_lft) e = e + {6'd0, r_win[1][ch*8 +: 8]};
            if (r_rgt) e = e + {6'd0, r_win[7][ch*8 +: 8]};
            if (r_lft && r_up) d = d + {6'd0, r_win[0][ch*8 +: 8]};
            if (r_lft && r_dn) d = d + {6'd0, r_win[2][ch*8 +: 8]};
            if (r_rgt && r_up) d = d + {6'd0, r_win[6][ch*8 +: 8]};
            if (r_rgt && r_dn) d = d + {6'd0, r_win[8][ch*8 +: 8]};
            n_sum[ch] = (c * 14'd12) - (e <<< 1) - d;

            n_prod[ch] = (r_sum[ch][13] || r_sum[ch] == 14'd0) ? 20'd0 :
                         ({8'd0, r_sum[ch][11:0]} * {12'd0, r_strength});

            q10 = r_prod[ch][11:0] * 12'd3277;
            n_hp[ch] = (r_prod[ch] >= 20'd2560) ? 8'd255 : q10[22:15];

            lv = r_win[4][ch*8 +: 8];
            m = lv[7] ? (8'd255 - lv) : lv;
            n_x[ch] = ({9'd0, r_hp[ch]} * {9'd0, m}) << 1;

            q0w = {9'd0, r_x[ch]} * 26'd257;
            q0 = {7'd0, q0w[25:16]};
            rem = {1'b0, r_x[ch]} - (({1'b0, q0} << 8) - {1'b0, q0});
            q = (rem >= 18'd255) ? q0 + 17'd1 : q0;
            rr = lv[7] ? (q + ({9'd0, lv} << 1) - 17'd255) : q;
            n_res[ch] = rr[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.c1) r_sum <= n_sum;
        if (i_cmd.c2) r_prod <= n_prod;
        if (i_cmd.c3) r_hp <= n_hp;
        if (i_cmd.c4) r_x <= n_x;
        if (i_cmd.load) begin
            r_out <= {n_res[2], n_res[1], n_res[0]};
            r_out_last <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (i_cmd.load) r_out_valid <= 1'b1;
        else if (!i_out_stall) r_out_valid <= 1'b0;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_red = r_out[7:0];
    assign o_out_green = r_out[15:8];
    assign o_out_blue = r_out[23:16];
    assign o_frame_last = r_out_last;

endmodule

// ===== design/high_pass_overlay_sharpen.sv =====
// An ignored flush is taken every cycle; input stalls outside the idle state.
// A pixel with no result yet passes only the read state; one with a result also
// passes the five-step arithmetic sequence, which loads a free output register.
// Synchronous active-low reset clears counters, control and registers to defaults.
// Line buffers and the window hold no reset value.
module high_pass_overlay_sharpen #(
    parameter int MAX_WIDTH = hpos_pkg::MAX_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hpos_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hpos_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_pix_red,
    input  logic [7:0]                      i_pix_green,
    input  logic [7:0]                      i_pix_blue,
    input  logic                            i_flush,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_out_red,
    output logic [7:0]                      o_out_green,
    output logic [7:0]                      o_out_blue,
    output logic                            o_frame_last
);

    hpos_pkg::t_cmd cmd;
    hpos_pkg::t_sts sts;

    hpos_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    hpos_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_pix_red    (i_pix_red),
        .i_pix_green  (i_pix_green),
        .i_pix_blue   (i_pix_blue),
        .i_flush      (i_flush),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_red    (o_out_red),
        .o_out_green  (o_out_green),
        .o_out_blue   (o_out_blue),
        .o_frame_last (o_frame_last)
    );

endmodule
